// ===== sv/kms_pkg.sv =====
// kms_pkg: constants, codes, types and helpers shared by the key matrix scanner
// no dependencies
package kms_pkg;

   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int SCAN_SLOTS = 16;

   localparam int LEVEL_W = 16;
   localparam int ROW_W   = 4;
   localparam int KEY_W   = 8;
   localparam int CFG_W   = 5;
   localparam int COL_W   = 4;
   localparam int CNT_W   = $clog2(SCAN_SLOTS + 1);
   localparam int SLOT_W  = (SCAN_SLOTS > 1) ? $clog2(SCAN_SLOTS) : 1;

   typedef enum logic [1:0] {
      CSR_NUM_ROWS   = 2'd0,
      CSR_NUM_COLS   = 2'd1,
      CSR_ACTIVE_LOW = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_TICK_OUT,
      ST_LIST_RD,
      ST_LIST_OUT
   } state_type;

   // command from the sequencer that starts a column sweep
   typedef struct packed {
      logic               start;
      logic [LEVEL_W-1:0] levels;
      logic [COL_W-1:0]   last_col;
      logic [KEY_W-1:0]   base;
   } scan_cmd_type;

   // per-cycle result of the column unit
   typedef struct packed {
      logic             hit;
      logic [KEY_W-1:0] key;
      logic             done;
   } scan_stat_type;

   function automatic logic [CFG_W-1:0] clamp_count(logic [CFG_W-1:0] v,
                                                    logic [CFG_W-1:0] hi);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== sv/kms_if.sv =====
// kms_req_if and kms_rsp_if: valid/ready channels of the key matrix scanner
// depends on kms_pkg
interface kms_req_if import kms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] col_levels;

   modport source (output valid, output col_levels, input ready);
   modport sink (input valid, input col_levels, output ready);
endinterface

interface kms_rsp_if import kms_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] active_row;
   logic             key_valid;
   logic [KEY_W-1:0] key_index;
   logic             none_pressed;
   logic             frame_done;
   logic             last;

   modport source (output valid, output active_row, output key_valid, output key_index,
                   output none_pressed, output frame_done, output last, input ready);
   modport sink (input valid, input active_row, input key_valid, input key_index,
                 input none_pressed, input frame_done, input last, output ready);
endinterface

// ===== sv/kms_key_list.sv =====
// kms_key_list: scan list storage, one write and one registered read port
// depends on kms_pkg
module kms_key_list import kms_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  logic [KEY_W-1:0]  wr_data,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [KEY_W-1:0]  rd_data
);

   logic [KEY_W-1:0] mem [SCAN_SLOTS];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kms_col_scan.sv =====
// kms_col_scan: shared column unit, tests one column and forms its key per cycle
// depends on kms_pkg
module kms_col_scan import kms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  scan_cmd_type  cmd,
   output scan_stat_type stat
);

   logic               busy_ff, busy_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COL_W-1:0]   last_col_ff, last_col_in;
   logic [LEVEL_W-1:0] levels_ff, levels_in;
   logic [KEY_W-1:0]   base_ff, base_in;

   always_comb begin
      busy_in     = busy_ff;
      col_in      = col_ff;
      last_col_in = last_col_ff;
      levels_in   = levels_ff;
      base_in     = base_ff;
      stat.hit    = busy_ff & levels_ff[col_ff];
      stat.key    = base_ff + KEY_W'(col_ff);
      stat.done   = busy_ff & (col_ff == last_col_ff);
      if (cmd.start) begin
         busy_in     = 1'b1;
         col_in      = '0;
         last_col_in = cmd.last_col;
         levels_in   = cmd.levels;
         base_in     = cmd.base;
      end else if (busy_ff) begin
         col_in = col_ff + COL_W'(1);
         if (stat.done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      col_ff      <= col_in;
      last_col_ff <= last_col_in;
      levels_ff   <= levels_in;
      base_ff     <= base_in;
   end

endmodule

// ===== sv/key_matrix_scanner_core.sv =====
// key_matrix_scanner_core: tick sequencer, config registers and result port
// depends on kms_pkg, kms_if, kms_col_scan, kms_key_list
// flow: a tick is swept column by column in the column unit, then decided, then its
// result or, at a frame end with keys, each listed key read from the list is shown
// a new tick is taken only in idle, after every result of the last one is accepted
// reset: synchronous, row 0, empty list, num_rows 4, num_cols 4, active high keys
module key_matrix_scanner_core import kms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   kms_req_if.sink          req,
   kms_rsp_if.source        rsp,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [CFG_W-1:0] num_rows_ff, num_cols_ff;
   logic             active_low_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             out_none_ff, out_none_in;
   logic             out_done_ff, out_done_in;

   logic [CFG_W-1:0]       rows_eff, cols_eff;
   logic [ROW_W+CFG_W-1:0] base_full;
   logic                   list_last;
   logic                   wr_en;
   logic [KEY_W-1:0]       rd_data;
   scan_cmd_type           cmd;
   scan_stat_type          stat;

   assign rows_eff  = clamp_count(num_rows_ff, CFG_W'(MAX_ROWS));
   assign cols_eff  = clamp_count(num_cols_ff, CFG_W'(MAX_COLS));
   assign base_full = row_ff * cols_eff;
   assign list_last = (rd_idx_ff + CNT_W'(1)) == count_ff;

   assign cmd.start    = req.valid & req.ready;
   assign cmd.levels   = req.col_levels ^ {LEVEL_W{active_low_ff}};
   assign cmd.last_col = COL_W'(cols_eff - CFG_W'(1));
   assign cmd.base     = base_full[KEY_W-1:0];

   kms_col_scan u_col_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   kms_key_list u_key_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[SLOT_W-1:0]),
      .wr_data (stat.key),
      .rd_addr (rd_idx_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      out_row_in  = out_row_ff;
      out_none_in = out_none_ff;
      out_done_in = out_done_ff;
      wr_en       = 1'b0;

      req.ready        = (state_ff == ST_IDLE);
      rsp.valid        = (state_ff == ST_TICK_OUT) || (state_ff == ST_LIST_OUT);
      rsp.key_valid    = (state_ff == ST_LIST_OUT);
      rsp.key_index    = (state_ff == ST_LIST_OUT) ? rd_data : '0;
      rsp.active_row   = out_row_ff;
      rsp.none_pressed = out_none_ff;
      rsp.frame_done   = out_done_ff;
      rsp.last         = (state_ff == ST_TICK_OUT) ? 1'b1 : list_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // list saturates: extra keys in a frame are dropped
            if (stat.hit && (count_ff < CNT_W'(SCAN_SLOTS))) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            if (stat.done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            out_none_in = 1'b0;
            out_done_in = 1'b0;
            out_row_in  = '0;
            if ((CFG_W'(row_ff) + CFG_W'(1)) < rows_eff) begin
               row_in     = row_ff + ROW_W'(1);
               out_row_in = row_ff + ROW_W'(1);
               state_in   = ST_TICK_OUT;
            end else begin
               row_in      = '0;
               out_done_in = 1'b1;
               rd_idx_in   = '0;
               if (count_ff == '0) begin
                  out_none_in = 1'b1;
                  state_in    = ST_TICK_OUT;
               end else begin
                  state_in = ST_LIST_RD;
               end
            end
         end
         ST_TICK_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIST_RD: begin
            state_in = ST_LIST_OUT;
         end
         ST_LIST_OUT: begin
            if (rsp.ready) begin
               if (list_last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  state_in  = ST_LIST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         count_ff <= count_in;
      end
      rd_idx_ff   <= rd_idx_in;
      out_row_ff  <= out_row_in;
      out_none_ff <= out_none_in;
      out_done_ff <= out_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff   <= CFG_W'(4);
         num_cols_ff   <= CFG_W'(4);
         active_low_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_ROWS:   num_rows_ff   <= csr_wdata;
            CSR_NUM_COLS:   num_cols_ff   <= csr_wdata;
            CSR_ACTIVE_LOW: active_low_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== sv/kms_checker.sv =====
// kms_checker: port-level checks on the key matrix scanner, bound to the top level
// depends on kms_pkg for field widths
module kms_checker import kms_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [ROW_W-1:0] rsp_active_row,
   input logic             rsp_key_valid,
   input logic             rsp_none_pressed,
   input logic             rsp_frame_done,
   input logic             rsp_last
);

   // one item at a time: no new tick while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_scan_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result shown right after a tick was taken");

   a_key_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_valid) |->
         (rsp_frame_done && !rsp_none_pressed && (rsp_active_row == '0)))
      else $error("listed key outside a frame end");

   a_none_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_pressed) |-> (rsp_last && rsp_frame_done && !rsp_key_valid))
      else $error("none-pressed item malformed");

   // more keys follow a non-final item, so no new tick yet
   a_list_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> !req_ready)
      else $error("tick accepted in the middle of a key list");

endmodule

bind key_matrix_scanner_core kms_checker u_kms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_active_row   (rsp.active_row),
   .rsp_key_valid    (rsp.key_valid),
   .rsp_none_pressed (rsp.none_pressed),
   .rsp_frame_done   (rsp.frame_done),
   .rsp_last         (rsp.last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for key_matrix_scanner_core, predicts each scan result
// depends on kms_pkg, kms_req_if / kms_rsp_if and the scanner rtl
module tb_top;
   import kms_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0] active_row;
      logic             key_valid;
      logic [KEY_W-1:0] key_index;
      logic             none_pressed;
      logic             frame_done;
      logic             last;
   } scan_result_type;

   typedef enum logic {STEP_TICK, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      csr_index_type      sel;
      logic [LEVEL_W-1:0] data;
      logic               typed;
      scan_result_type    want;
   } stim_row_type;

   localparam scan_result_type NO_WANT = '0;
   localparam int N_DIRECTED      = 24;
   localparam int N_PHASES        = 6;
   localparam int TICKS_PER_PHASE = 17;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int CSR_SETTLE      = 8;
   localparam int TAIL_CYCLES     = 60;
   localparam int LONG_HOLD       = 400;
   localparam int MAX_PRINTED     = 50;

   // default setup is 4 rows x 4 cols, keys active high
   localparam stim_row_type DIRECTED_STEPS [0:N_DIRECTED-1] = '{
      '{STEP_TICK, CSR_NUM_ROWS,   16'h0000, 1'b1, '{4'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'h0000, 1'b1, '{4'd2, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'h0000, 1'b1, '{4'd3, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'h0000, 1'b1, '{4'd0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'hffff, 1'b1, '{4'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'hffff, 1'b1, '{4'd2, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'hffff, 1'b1, '{4'd3, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      // every key down, list exactly full
      '{STEP_TICK, CSR_NUM_ROWS,   16'hffff, 1'b0, NO_WANT},
      '{STEP_CSR,  CSR_NUM_ROWS,   16'd2,    1'b0, NO_WANT},
      '{STEP_CSR,  CSR_NUM_COLS,   16'd16,   1'b0, NO_WANT},
      '{STEP_TICK, CSR_NUM_ROWS,   16'hffff, 1'b1, '{4'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      // second row overflows the list, its keys are dropped
      '{STEP_TICK, CSR_NUM_ROWS,   16'hffff, 1'b0, NO_WANT},
      '{STEP_CSR,  CSR_ACTIVE_LOW, 16'd1,    1'b0, NO_WANT},
      '{STEP_CSR,  CSR_NUM_COLS,   16'd0,    1'b0, NO_WANT},
      '{STEP_CSR,  CSR_NUM_ROWS,   16'd0,    1'b0, NO_WANT},
      // zero counts read as one row, one column
      '{STEP_TICK, CSR_NUM_ROWS,   16'hffff, 1'b1, '{4'd0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'h0000, 1'b1, '{4'd0, 1'b1, 8'd0, 1'b0, 1'b1, 1'b1}},
      '{STEP_CSR,  CSR_NUM_ROWS,   16'd31,   1'b0, NO_WANT},
      '{STEP_CSR,  CSR_NUM_COLS,   16'd31,   1'b0, NO_WANT},
      '{STEP_CSR,  CSR_ACTIVE_LOW, 16'd0,    1'b0, NO_WANT},
      '{STEP_TICK, CSR_NUM_ROWS,   16'h8001, 1'b1, '{4'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      '{STEP_TICK, CSR_NUM_ROWS,   16'h0000, 1'b1, '{4'd2, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1}},
      // row count lowered to the current row, this tick closes the frame
      '{STEP_CSR,  CSR_NUM_ROWS,   16'd2,    1'b0, NO_WANT},
      '{STEP_TICK, CSR_NUM_ROWS,   16'h0000, 1'b0, NO_WANT}
   };

   // phase setups, the last one is drawn at random
   localparam logic [CFG_W-1:0] PHASE_ROWS [0:N_PHASES-1] = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd0};
   localparam logic [CFG_W-1:0] PHASE_COLS [0:N_PHASES-1] = '{5'd4, 5'd16, 5'd1, 5'd31, 5'd0, 5'd0};
   localparam logic             PHASE_LOW  [0:N_PHASES-1] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [CFG_W-1:0] csr_wdata;

   kms_req_if req ();
   kms_rsp_if rsp ();

   key_matrix_scanner_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow and scan state of the predictor
   logic [CFG_W-1:0] cfg_rows;
   logic [CFG_W-1:0] cfg_cols;
   logic             cfg_active_low;
   int               scan_row;
   int               scan_count;
   logic [KEY_W-1:0] scan_keys [SCAN_SLOTS];

   scan_result_type  tick_results [$];
   scan_result_type  pending_results [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int mismatches;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTED) begin
         $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   // results of one scan tick, also advances the scan state
   function automatic void predict_scan_tick(input logic [LEVEL_W-1:0] levels);
      int rows;
      int cols;
      scan_result_type r;
      tick_results.delete();
      rows = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      cols = (cfg_cols == 0) ? 1 : (cfg_cols > MAX_COLS) ? MAX_COLS : int'(cfg_cols);
      for (int c = 0; c < cols; c++) begin
         if ((levels[c] ^ cfg_active_low) && scan_count < SCAN_SLOTS) begin
            scan_keys[scan_count] = KEY_W'(c + scan_row * cols);
            scan_count++;
         end
      end
      if (scan_row + 1 < rows) begin
         scan_row++;
         r = '{ROW_W'(scan_row), 1'b0, 8'd0, 1'b0, 1'b0, 1'b1};
         tick_results.push_back(r);
      end else begin
         scan_row = 0;
         if (scan_count == 0) begin
            r = '{4'd0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1};
            tick_results.push_back(r);
         end
         for (int i = 0; i < scan_count; i++) begin
            r = '{4'd0, 1'b1, scan_keys[i], 1'b0, 1'b1, (i == scan_count - 1)};
            tick_results.push_back(r);
         end
         scan_count = 0;
      end
   endfunction

   // mostly a few pressed keys, sometimes noise or everything down
   function automatic logic [LEVEL_W-1:0] random_levels();
      logic [LEVEL_W-1:0] v;
      int pick;
      int k;
      pick = $urandom_range(9);
      v = cfg_active_low ? 16'hffff : 16'h0000;
      if (pick < 6) begin
         repeat ($urandom_range(3)) begin
            k = $urandom_range(LEVEL_W - 1);
            v[k] = ~v[k];
         end
      end else if (pick < 9) begin
         v = LEVEL_W'($urandom);
      end else begin
         v = ~v;
      end
      return v;
   endfunction

   task automatic send_tick(input logic [LEVEL_W-1:0] levels, input logic typed,
                            input scan_result_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.col_levels <= levels;
      do @(posedge clock); while (!req.ready);
      predict_scan_tick(levels);
      if (typed) begin
         pending_results.push_back(want);
      end else begin
         foreach (tick_results[i]) pending_results.push_back(tick_results[i]);
      end
   endtask

   task automatic drain_results(input bit settle);
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      if (settle) repeat (CSR_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (sel)
         CSR_NUM_ROWS: cfg_rows = value;
         CSR_NUM_COLS: cfg_cols = value;
         default: cfg_active_low = value[0];
      endcase
   endtask

   // receiver, with an optional long hold-off counted here
   initial begin : receiver
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      scan_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("item with nothing pending, key_index", rsp.key_index, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp.active_row !== want.active_row)
               report_mismatch("active_row", rsp.active_row, want.active_row);
            if (rsp.key_valid !== want.key_valid)
               report_mismatch("key_valid", rsp.key_valid, want.key_valid);
            if (rsp.key_index !== want.key_index)
               report_mismatch("key_index", rsp.key_index, want.key_index);
            if (rsp.none_pressed !== want.none_pressed)
               report_mismatch("none_pressed", rsp.none_pressed, want.none_pressed);
            if (rsp.frame_done !== want.frame_done)
               report_mismatch("frame_done", rsp.frame_done, want.frame_done);
            if (rsp.last !== want.last)
               report_mismatch("last", rsp.last, want.last);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] rows_val;
      logic [CFG_W-1:0] cols_val;
      logic             low_val;
      reset = 1'b1;
      req.valid = 1'b0;
      req.col_levels = '0;
      csr_we = 1'b0;
      csr_index = CSR_NUM_ROWS;
      csr_wdata = '0;
      cfg_rows = 5'd4;
      cfg_cols = 5'd4;
      cfg_active_low = 1'b0;
      scan_row = 0;
      scan_count = 0;
      hold_left = 0;
      mismatches = 0;
      send_idle_pct = 9;
      recv_idle_pct = 61;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED_STEPS[i].kind == STEP_CSR) begin
            drain_results(1'b1);
            write_reg(DIRECTED_STEPS[i].sel, DIRECTED_STEPS[i].data[CFG_W-1:0]);
         end else begin
            send_tick(DIRECTED_STEPS[i].data, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         drain_results(1'b1);
         send_idle_pct = (p < 2) ? 9 : (p < 4) ? 61 : 0;
         recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 9 : 0;
         // one frame end per item here, so the result side backs up into the input
         if (p == 1) hold_left = LONG_HOLD;
         if (p == N_PHASES - 1) begin
            rows_val = CFG_W'($urandom_range(31));
            cols_val = CFG_W'($urandom_range(31));
            low_val = 1'($urandom_range(1));
         end else begin
            rows_val = PHASE_ROWS[p];
            cols_val = PHASE_COLS[p];
            low_val = PHASE_LOW[p];
         end
         write_reg(CSR_NUM_ROWS, rows_val);
         write_reg(CSR_NUM_COLS, cols_val);
         write_reg(CSR_ACTIVE_LOW, {{(CFG_W-1){1'b0}}, low_val});
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (p == 3 && n == TICKS_PER_PHASE / 2) drain_results(1'b0);
            send_tick(random_levels(), 1'b0, NO_WANT);
         end
      end

      drain_results(1'b0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
